// ----- design/sbpd_pkg.sv -----
// Shared types and constants for the spectrum bin power to dB converter.
`timescale 1ns / 1ps

package sbpd_pkg;

	localparam int POWER_W = 48;
	localparam int LEVEL_W = 40;
	localparam int INDEX_W = 12;
	localparam int CFG_W   = 48;
	localparam int CFG_IDX_W = 3;
	localparam int BASE_W  = 24;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CROP_PERCENT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOPPING_ENABLED = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LINEAR_MODE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BASELINE_ENABLE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BASELINE_VALUE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NORM_DIVISOR    = 3'd6;

	// 10*log10(2) in Q.24
	localparam logic [31:0] DB_COEF = 32'd50504453;
	// linear quotient cap, 2^41
	localparam logic [42:0] Q_CAP = 43'h200_0000_0000;
	localparam logic signed [LEVEL_W-1:0] LVL_MAX = 40'sh7F_FFFF_FFFF;
	localparam logic signed [LEVEL_W-1:0] LVL_MIN = 40'sh80_0000_0000;
	// floor(x/100) == (x * CROP_RECIP) >> CROP_SHIFT for x below 2^23
	localparam logic [23:0] CROP_RECIP = 24'd10737419;
	localparam int CROP_SHIFT = 30;
	localparam logic [6:0] CROP_MAX = 7'd100;

	// settings the arithmetic unit needs for one conversion
	typedef struct packed {
		logic                      linear;
		logic                      base_en;
		logic signed [BASE_W-1:0]  baseline;
		logic [POWER_W-1:0]        divisor;
	} sbpd_cfg_t;

endpackage

// ----- design/sbpd_in_if.sv -----
// Input channel: one accumulated bin power per transfer.
`timescale 1ns / 1ps

interface sbpd_in_if import sbpd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [POWER_W-1:0] bin_power;

	modport source (output valid, output bin_power, input ready);
	modport sink (input valid, input bin_power, output ready);
endinterface

// ----- design/sbpd_out_if.sv -----
// Output channel: one bin level per transfer.
`timescale 1ns / 1ps

interface sbpd_out_if import sbpd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [INDEX_W-1:0]        bin_index;
	logic signed [LEVEL_W-1:0] level;
	logic                      last_of_run;
	logic                      last_of_frame;

	modport source (output valid, output bin_index, output level, output last_of_run,
		output last_of_frame, input ready);
	modport sink (input valid, input bin_index, input level, input last_of_run,
		input last_of_frame, output ready);
endinterface

// ----- design/sbpd_unit.sv -----
// Iterative arithmetic unit: restoring divide or log2 by squaring, one shared multiplier.
`timescale 1ns / 1ps

module sbpd_unit import sbpd_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [POWER_W-1:0]        power,
	input  sbpd_cfg_t                 cfg,
	output logic                      done,
	output logic signed [LEVEL_W-1:0] level
);

	localparam int DIV_STEPS = POWER_W + FRAC_BITS;
	localparam int SH = 54 - FRAC_BITS;
	localparam logic [63:0] RND = 64'd1 << (SH - 1);

	localparam logic [2:0] U_IDLE = 3'd0;
	localparam logic [2:0] U_DIV  = 3'd1;
	localparam logic [2:0] U_NORM = 3'd2;
	localparam logic [2:0] U_SQ   = 3'd3;
	localparam logic [2:0] U_MUL0 = 3'd4;
	localparam logic [2:0] U_MUL1 = 3'd5;
	localparam logic [2:0] U_FIN  = 3'd6;

	logic [2:0]                st_q;
	logic [6:0]                cnt_q;
	logic [POWER_W:0]          r_q;
	logic [42:0]               q_q;
	logic [POWER_W-1:0]        x_q;
	logic [5:0]                e_q;
	logic [31:0]               y_q;
	logic [29:0]               frac_q;
	logic [35:0]               lp_q;
	logic [35:0]               mag_q;
	logic                      neg_q;
	logic                      second_q;
	logic                      zero_q;
	logic                      lin_q;
	logic [63:0]               acc_q;
	logic                      done_q;
	logic signed [LEVEL_W-1:0] level_q;

	logic [POWER_W-1:0] dvs;
	assign dvs = (cfg.divisor == '0) ? POWER_W'(1) : cfg.divisor;

	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	always_comb begin
		unique case (st_q)
			U_SQ: begin
				mul_a = y_q;
				mul_b = y_q;
			end
			U_MUL0: begin
				mul_a = mag_q[31:0];
				mul_b = DB_COEF;
			end
			U_MUL1: begin
				mul_a = {28'd0, mag_q[35:32]};
				mul_b = DB_COEF;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// one restoring divide step
	logic [POWER_W:0] r_sh, r_nx;
	logic [43:0]      q_sh;
	logic [42:0]      q_nx;
	always_comb begin
		r_sh = {r_q[POWER_W-1:0], x_q[POWER_W-1]};
		q_sh = {q_q, 1'b0};
		if (r_sh >= {1'b0, dvs}) begin
			r_nx = r_sh - {1'b0, dvs};
			q_sh[0] = 1'b1;
		end else begin
			r_nx = r_sh;
		end
		q_nx = (q_sh > {1'b0, Q_CAP}) ? Q_CAP : q_sh[42:0];
	end

	// binary-search normalize: one shift amount per cycle
	logic [POWER_W-1:0] x_nx;
	logic [5:0]         e_nx;
	always_comb begin
		x_nx = x_q;
		e_nx = e_q;
		unique case (cnt_q)
			7'd0: if (x_q[47:16] == '0) begin
				x_nx = {x_q[15:0], 32'd0};
				e_nx = e_q - 6'd32;
			end
			7'd1: if (x_q[47:32] == '0) begin
				x_nx = {x_q[31:0], 16'd0};
				e_nx = e_q - 6'd16;
			end
			7'd2: if (x_q[47:40] == '0) begin
				x_nx = {x_q[39:0], 8'd0};
				e_nx = e_q - 6'd8;
			end
			7'd3: if (x_q[47:44] == '0) begin
				x_nx = {x_q[43:0], 4'd0};
				e_nx = e_q - 6'd4;
			end
			7'd4: if (x_q[47:46] == '0) begin
				x_nx = {x_q[45:0], 2'd0};
				e_nx = e_q - 6'd2;
			end
			7'd5: if (!x_q[47]) begin
				x_nx = {x_q[46:0], 1'b0};
				e_nx = e_q - 6'd1;
			end
			default: ;
		endcase
	end

	// one squaring step of the fraction
	logic [32:0] sq;
	logic [31:0] y_nx;
	logic [29:0] frac_nx;
	logic [35:0] lg;
	always_comb begin
		sq = mul_p[63:31];
		if (sq[32]) begin
			y_nx = sq[32:1];
			frac_nx = {frac_q[28:0], 1'b1};
		end else begin
			y_nx = sq[31:0];
			frac_nx = {frac_q[28:0], 1'b0};
		end
		lg = {e_q, frac_nx};
	end

	// final scaling, baseline and saturation
	logic [63:0]        rnd;
	logic signed [47:0] mag48, val, val_b;
	logic signed [LEVEL_W-1:0] lvl_nx;
	always_comb begin
		rnd = (acc_q + RND) >> SH;
		mag48 = signed'(48'(rnd));
		if (lin_q)
			val = signed'({5'd0, q_q});
		else
			val = neg_q ? -mag48 : mag48;
		val_b = cfg.base_en ? val - 48'(cfg.baseline) : val;
		if (val_b > 48'(LVL_MAX))
			lvl_nx = LVL_MAX;
		else if (val_b < 48'(LVL_MIN))
			lvl_nx = LVL_MIN;
		else
			lvl_nx = val_b[LEVEL_W-1:0];
		if (zero_q)
			lvl_nx = LVL_MIN;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= U_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				U_IDLE: if (start) begin
					if (cfg.linear)
						st_q <= U_DIV;
					else if (power == '0)
						st_q <= U_FIN;
					else
						st_q <= U_NORM;
				end
				U_DIV: if (cnt_q == 7'(DIV_STEPS - 1))
					st_q <= U_FIN;
				U_NORM: if (cnt_q == 7'd5)
					st_q <= U_SQ;
				U_SQ: if (cnt_q == 7'd29)
					st_q <= second_q ? U_MUL0 : U_NORM;
				U_MUL0: st_q <= U_MUL1;
				U_MUL1: st_q <= U_FIN;
				U_FIN: begin
					st_q <= U_IDLE;
					done_q <= 1'b1;
				end
				default: st_q <= U_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			U_IDLE: if (start) begin
				lin_q <= cfg.linear;
				zero_q <= !cfg.linear && (power == '0);
				x_q <= power;
				e_q <= 6'd47;
				r_q <= '0;
				q_q <= '0;
				cnt_q <= '0;
				second_q <= 1'b0;
			end
			U_DIV: begin
				r_q <= r_nx;
				q_q <= q_nx;
				x_q <= {x_q[POWER_W-2:0], 1'b0};
				cnt_q <= cnt_q + 7'd1;
			end
			U_NORM: begin
				x_q <= x_nx;
				e_q <= e_nx;
				if (cnt_q == 7'd5) begin
					y_q <= x_nx[47:16];
					frac_q <= '0;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + 7'd1;
				end
			end
			U_SQ: begin
				y_q <= y_nx;
				frac_q <= frac_nx;
				if (cnt_q == 7'd29) begin
					cnt_q <= '0;
					if (!second_q) begin
						lp_q <= lg;
						second_q <= 1'b1;
						x_q <= dvs;
						e_q <= 6'd47;
					end else begin
						neg_q <= lp_q < lg;
						mag_q <= (lp_q < lg) ? lg - lp_q : lp_q - lg;
					end
				end else begin
					cnt_q <= cnt_q + 7'd1;
				end
			end
			U_MUL0: acc_q <= mul_p;
			U_MUL1: acc_q <= acc_q + {mul_p[31:0], 32'd0};
			U_FIN: level_q <= lvl_nx;
			default: ;
		endcase
	end

	assign done = done_q;
	assign level = level_q;

endmodule

// ----- design/spectrum_bin_power_to_db.sv -----
// Top level: frame bookkeeping, center bin interpolation, result register.
`timescale 1ns / 1ps

// Converts accumulated FFT bin powers, one per transfer in bin order, into
// Q.FRAC_BITS levels (linear or 10*log10), with the center bin replaced by the
// mean of its neighbors and optional edge cropping and baseline subtraction.
// One item occupies the block for its transfer and the setup states (SETUP,
// EX, PLAN), plus one pass of the shared arithmetic unit per result. A pass
// in linear mode runs one divide step per quotient bit, then finish, hand-off
// and output load; in log mode it runs two log2 evaluations (normalize and
// squaring steps), a multiply of the low and then the high part, and the same
// finish, hand-off and load; a zero power in log mode goes straight to the
// finish. The item for bin N/2+1 carries two results and takes two passes;
// the center bin item takes only the setup. The input is ready again once
// the last result of an item sits in the output register; a result that is
// not taken holds off the next load and with it the input.

module spectrum_bin_power_to_db import sbpd_pkg::*; #(
	parameter int MAX_BINS  = 4096,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	sbpd_in_if.sink              in_ch,
	sbpd_out_if.source           out_ch
);

	localparam int CW = $clog2(MAX_BINS);
	localparam int NW = $clog2(MAX_BINS + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SETUP = 3'd1;
	localparam logic [2:0] S_EX    = 3'd2;
	localparam logic [2:0] S_PLAN  = 3'd3;
	localparam logic [2:0] S_RUN   = 3'd4;
	localparam logic [2:0] S_PUSH  = 3'd5;

	// configuration registers
	logic [12:0]              bins_q;
	logic [6:0]               crop_q;
	logic                     hop_q, lin_q, base_en_q;
	logic signed [BASE_W-1:0] base_q;
	logic [POWER_W-1:0]       div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q <= 13'd1024;
			crop_q <= '0;
			hop_q <= 1'b0;
			lin_q <= 1'b0;
			base_en_q <= 1'b0;
			base_q <= 24'sd1966080;
			div_q <= POWER_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BINS_IN_USE:     bins_q <= cfg_data[12:0];
				REG_CROP_PERCENT:    crop_q <= cfg_data[6:0];
				REG_HOPPING_ENABLED: hop_q <= cfg_data[0];
				REG_LINEAR_MODE:     lin_q <= cfg_data[0];
				REG_BASELINE_ENABLE: base_en_q <= cfg_data[0];
				REG_BASELINE_VALUE:  base_q <= signed'(cfg_data[BASE_W-1:0]);
				REG_NORM_DIVISOR:    div_q <= cfg_data[POWER_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped bin count and crop
	logic [NW-1:0] n_cl;
	logic [6:0]    crop_cl;
	always_comb begin
		if (32'(bins_q) < 32'd4)
			n_cl = NW'(4);
		else if (32'(bins_q) > 32'(MAX_BINS))
			n_cl = NW'(MAX_BINS);
		else
			n_cl = NW'(bins_q);
		crop_cl = (crop_q > CROP_MAX) ? CROP_MAX : crop_q;
		if (!hop_q)
			crop_cl = '0;
	end

	logic [2:0]          st_q;
	logic [POWER_W-1:0]  p_q, held_q;
	logic [CW-1:0]       cnt_q;
	logic [NW+6:0]       nc_q;
	logic [NW-1:0]       ex_q;
	logic [NW-1:0]       c_q, i_q, hi_q;
	logic                mjob_q, cur_center_q;

	logic [NW+30:0] ex_prod;
	assign ex_prod = nc_q * CROP_RECIP;

	// frame position for the held item
	logic [NW-1:0] c_w, i_w, lo_w, hi_w, i_nx;
	logic          is_left, is_center, do_c, do_m;
	logic [POWER_W:0] sum_w;
	always_comb begin
		c_w = n_cl >> 1;
		i_w = (NW'(cnt_q) < n_cl) ? NW'(cnt_q) : '0;
		lo_w = ex_q;
		hi_w = n_cl - ex_q;
		is_left = (i_w == c_w - NW'(1));
		is_center = (i_w == c_w);
		do_c = !is_left && !is_center && (i_w == c_w + NW'(1)) && (c_w >= lo_w)
			&& (c_w < hi_w);
		do_m = !is_center && (i_w >= lo_w) && (i_w < hi_w);
		i_nx = (i_w + NW'(1) >= n_cl) ? '0 : i_w + NW'(1);
		sum_w = {1'b0, held_q} + {1'b0, p_q};
	end

	// arithmetic unit
	sbpd_cfg_t          u_cfg;
	logic               u_start, u_done;
	logic [POWER_W-1:0] u_power;
	logic signed [LEVEL_W-1:0] u_level;

	assign u_cfg = '{linear: lin_q, base_en: base_en_q, baseline: base_q, divisor: div_q};

	// output register
	logic                      ov_q;
	logic [INDEX_W-1:0]        oidx_q;
	logic signed [LEVEL_W-1:0] olvl_q;
	logic                      orun_q, oframe_q;
	logic                      slot_free, load;
	logic [NW-1:0]             idx_w;

	assign slot_free = !ov_q || out_ch.ready;
	assign load = (st_q == S_PUSH) && slot_free;
	assign idx_w = cur_center_q ? c_q : i_q;

	assign u_start = ((st_q == S_PLAN) && (do_c || do_m))
		|| (load && cur_center_q && mjob_q);
	assign u_power = ((st_q == S_PLAN) && do_c) ? sum_w[POWER_W:1] : p_q;

	sbpd_unit #(.FRAC_BITS(FRAC_BITS)) u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (u_start),
		.power  (u_power),
		.cfg    (u_cfg),
		.done   (u_done),
		.level  (u_level)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			cnt_q <= '0;
			held_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: if (in_ch.valid) st_q <= S_SETUP;
				S_SETUP: st_q <= S_EX;
				S_EX: st_q <= S_PLAN;
				S_PLAN: begin
					if (is_left) held_q <= p_q;
					cnt_q <= CW'(i_nx);
					st_q <= (do_c || do_m) ? S_RUN : S_IDLE;
				end
				S_RUN: if (u_done) st_q <= S_PUSH;
				S_PUSH: if (slot_free)
					st_q <= (cur_center_q && mjob_q) ? S_RUN : S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// per-item registers
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && in_ch.valid) p_q <= in_ch.bin_power;
		if (st_q == S_SETUP) nc_q <= n_cl * crop_cl;
		if (st_q == S_EX) ex_q <= NW'(ex_prod >> (CROP_SHIFT + 1));
		if (st_q == S_PLAN) begin
			c_q <= c_w;
			i_q <= i_w;
			hi_q <= hi_w;
			mjob_q <= do_m;
			cur_center_q <= do_c;
		end
		if (load) cur_center_q <= 1'b0;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (load)
			ov_q <= 1'b1;
		else if (out_ch.ready)
			ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			oidx_q <= INDEX_W'(idx_w);
			olvl_q <= u_level;
			orun_q <= !(cur_center_q && mjob_q);
			oframe_q <= ({1'b0, idx_w} + (NW+1)'(1)) == {1'b0, hi_q};
		end
	end

	assign in_ch.ready = (st_q == S_IDLE);
	assign out_ch.valid = ov_q;
	assign out_ch.bin_index = oidx_q;
	assign out_ch.level = olvl_q;
	assign out_ch.last_of_run = orun_q;
	assign out_ch.last_of_frame = oframe_q;

	// checks
	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		u_done |-> st_q == S_RUN)
		else $error("unit finished outside of a run");
	a_valid_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(st_q) == S_PUSH)
		else $error("result appeared without a push");
	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> st_q == S_SETUP)
		else $error("accepted item did not start setup");

endmodule
